[rtl/stp_pkg.sv]
package stp_pkg;

  // default sizing
  localparam int STP_MAX_CHANNELS = 8;
  localparam int STP_SINE_DEPTH   = 1024;

  // field widths
  localparam int STP_FREQ_W    = 17;
  localparam int STP_RATE_W    = 18;
  localparam int STP_CCNT_W    = 4;
  localparam int STP_LOOP_W    = 24;
  localparam int STP_SAMPLE_W  = 16;
  localparam int STP_CHAN_W    = 3;
  localparam int STP_CFG_IDX_W = 3;
  localparam int STP_CFG_DAT_W = 24;

  // channel counter holds up to 31
  localparam int STP_CNT_W   = 5;
  // shared step counter: residue reduction and phase division
  localparam int STP_STEP_W  = 5;
  localparam int STP_MOD_STEPS = STP_RATE_W;

  // scaling constants
  localparam int STP_FULL_Q15 = 32767;
  localparam int STP_S8_SCALE = 127;
  localparam int STP_U8_SCALE = 255;
  localparam int STP_U16_MAX  = 65535;

  // register reset values
  localparam logic [STP_FREQ_W-1:0] STP_RST_FREQ  = 17'd1000;
  localparam logic [STP_RATE_W-1:0] STP_RST_RATE  = 18'd48000;
  localparam logic                  STP_RST_WIDE  = 1'b1;
  localparam logic                  STP_RST_SGN   = 1'b1;
  localparam logic [STP_CCNT_W-1:0] STP_RST_CCNT  = 4'd2;
  localparam logic [STP_LOOP_W-1:0] STP_RST_LOOP  = 24'd48000;

  typedef enum logic [STP_CFG_IDX_W-1:0] {
    CFG_TONE_FREQ   = 3'd0,
    CFG_SAMPLE_RATE = 3'd1,
    CFG_WIDE        = 3'd2,
    CFG_SIGNED      = 3'd3,
    CFG_CHAN_COUNT  = 3'd4,
    CFG_LOOP_FRAMES = 3'd5
  } stp_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_MULT,
    ST_DIV,
    ST_QUAD,
    ST_ROM,
    ST_SCALE,
    ST_FIN,
    ST_EMIT
  } stp_state_t;

  typedef struct packed {
    logic                  start;
    logic                  mod_step;
    logic                  mult;
    logic                  div_step;
    logic                  quad;
    logic                  rom;
    logic                  scale;
    logic                  fin;
    logic                  beat;
    logic                  beat_last;
    logic [STP_CHAN_W-1:0] beat_chan;
  } stp_cmd_t;

  typedef struct packed {
    logic                  out_free;
    logic [STP_CCNT_W-1:0] chan_cfg;
  } stp_sts_t;

  // a * b / 2^30, truncated toward zero; b non-negative
  function automatic longint stp_mul_q30(input longint a, input longint unsigned b);
    longint unsigned mag;
    longint unsigned prod;
    longint          res;
    if (a < 0) begin
      mag = longint'(-a);
    end else begin
      mag = longint'(a);
    end
    prod = (mag * b) >> 30;
    if (a < 0) begin
      res = -longint'(prod);
    end else begin
      res = longint'(prod);
    end
    return res;
  endfunction

  // quarter-wave entry in Q0.15 from the angle x in Q30 (x = k/D)
  function automatic logic [14:0] stp_quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint          p;
    longint          y;
    x2 = (x * x) >> 30;
    p  = 172272;
    p  = -5026995   + stp_mul_q30(p, x2);
    p  = 85569307   + stp_mul_q30(p, x2);
    p  = -693598668 + stp_mul_q30(p, x2);
    p  = 1686629713 + stp_mul_q30(p, x2);
    y  = stp_mul_q30(p, x);
    if (y < 0) begin
      y = 0;
    end
    y = (y + 16384) >>> 15;
    if (y > 32767) begin
      y = 32767;
    end
    return y[14:0];
  endfunction

endpackage

[rtl/stp_ctrl.sv]
module stp_ctrl #(
  parameter int MAX_CHANNELS     = stp_pkg::STP_MAX_CHANNELS,
  parameter int SINE_TABLE_DEPTH = stp_pkg::STP_SINE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              idle,
  input  stp_pkg::stp_sts_t sts,
  output stp_pkg::stp_cmd_t cmd
);
  import stp_pkg::*;

  localparam int QW = $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam logic [STP_CNT_W-1:0] MAXC = STP_CNT_W'(MAX_CHANNELS);

  stp_state_t            state_r, state_nxt;
  logic [STP_STEP_W-1:0] step_r, step_nxt;
  logic [STP_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STP_CNT_W-1:0]  chans;
  logic                  last;

  // zero channels means one; clip at the build limit
  always_comb begin
    if (sts.chan_cfg == '0) begin
      chans = STP_CNT_W'(1);
    end else if ({1'b0, sts.chan_cfg} > MAXC) begin
      chans = MAXC;
    end else begin
      chans = {1'b0, sts.chan_cfg};
    end
  end

  assign last = (cnt_r + STP_CNT_W'(1)) == chans;
  assign idle = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.beat_chan = cnt_r[STP_CHAN_W-1:0];
    cmd.beat_last = last;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          step_nxt  = STP_STEP_W'(STP_MOD_STEPS - 1);
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_MULT;
        end else begin
          step_nxt = step_r - STP_STEP_W'(1);
        end
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        step_nxt  = STP_STEP_W'(QW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_QUAD;
        end else begin
          step_nxt = step_r - STP_STEP_W'(1);
        end
      end
      ST_QUAD: begin
        cmd.quad  = 1'b1;
        state_nxt = ST_ROM;
      end
      ST_ROM: begin
        cmd.rom   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.beat = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + STP_CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/stp_datapath.sv]
module stp_datapath #(
  parameter int SINE_TABLE_DEPTH = stp_pkg::STP_SINE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stp_pkg::stp_cmd_t                   cmd,
  output stp_pkg::stp_sts_t                   sts,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stp_pkg::STP_SAMPLE_W-1:0]    out_sample,
  output logic [stp_pkg::STP_CHAN_W-1:0]      out_channel,
  output logic                                out_last_channel,
  input  logic                                cfg_wr,
  input  logic [stp_pkg::STP_CFG_IDX_W-1:0]   cfg_index,
  input  logic [stp_pkg::STP_CFG_DAT_W-1:0]   cfg_data
);
  import stp_pkg::*;

  localparam int unsigned D = SINE_TABLE_DEPTH;
  localparam int QW = $clog2(4 * D + 1);
  localparam int AW = $clog2(D + 1);
  localparam int NW = STP_RATE_W + $clog2(8 * D) + 1;
  localparam int unsigned EIGHT_D = 8 * D;
  localparam int RW = STP_RATE_W;

  // configuration
  logic [STP_FREQ_W-1:0] freq_r;
  logic [RW-1:0]         rate_r;
  logic                  wide_r;
  logic                  sgn_r;
  logic [STP_CCNT_W-1:0] ccnt_r;
  logic [STP_LOOP_W-1:0] loop_r;
  logic [RW-1:0]         rate_eff;

  // phase state
  logic [RW-1:0]         residue_r;
  logic [STP_LOOP_W-1:0] pos_r;

  // residue reduction
  logic [RW-1:0] dvd_res_r, dvd_frq_r, rem_res_r, rem_frq_r;
  logic [RW:0]   sh_res, sh_frq;
  logic [RW-1:0] rem_res_nxt, rem_frq_nxt;

  // frame advance
  logic [RW:0]           sum_adv;
  logic [RW-1:0]         res_adv;
  logic [STP_LOOP_W-1:0] pos_inc;

  // phase index division
  logic [NW-1:0] num_w;
  logic [RW:0]   rem_div_r;
  logic [QW-1:0] qlo_r;
  logic [RW+1:0] sh_div, div2;
  logic          div_ge;

  // quadrant fold
  logic [QW-1:0] idx_i, m_i;
  logic [1:0]    quad_i;
  logic [AW-1:0] addr_nxt, addr_r;
  logic          neg_r;

  // sine table
  logic [14:0] rom_w [0:D];
  logic [14:0] rom_q_r;

  // scaling
  logic [15:0] u_w, s16_w;
  logic [15:0] wide_res_r;
  logic [23:0] prod_r;
  logic [24:0] corr_w;
  logic [7:0]  q8_w, narrow_w;
  logic [15:0] sample_r;

  // result register
  logic                    out_valid_r;
  logic [STP_SAMPLE_W-1:0] out_sample_r;
  logic [STP_CHAN_W-1:0]   out_channel_r;
  logic                    out_last_r;

  assign rate_eff = (rate_r == '0) ? RW'(1) : rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= STP_RST_FREQ;
      rate_r <= STP_RST_RATE;
      wide_r <= STP_RST_WIDE;
      sgn_r  <= STP_RST_SGN;
      ccnt_r <= STP_RST_CCNT;
      loop_r <= STP_RST_LOOP;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_TONE_FREQ:   freq_r <= cfg_data[STP_FREQ_W-1:0];
        CFG_SAMPLE_RATE: rate_r <= cfg_data[RW-1:0];
        CFG_WIDE:        wide_r <= cfg_data[0];
        CFG_SIGNED:      sgn_r  <= cfg_data[0];
        CFG_CHAN_COUNT:  ccnt_r <= cfg_data[STP_CCNT_W-1:0];
        CFG_LOOP_FRAMES: loop_r <= cfg_data[STP_LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring remainder steps, residue and frequency side by side
  assign sh_res = {rem_res_r, dvd_res_r[RW-1]};
  assign sh_frq = {rem_frq_r, dvd_frq_r[RW-1]};
  assign rem_res_nxt = (sh_res >= {1'b0, rate_eff}) ? RW'(sh_res - {1'b0, rate_eff})
                                                   : sh_res[RW-1:0];
  assign rem_frq_nxt = (sh_frq >= {1'b0, rate_eff}) ? RW'(sh_frq - {1'b0, rate_eff})
                                                   : sh_frq[RW-1:0];

  assign sum_adv = {1'b0, rem_res_r} + {1'b0, rem_frq_r};
  assign res_adv = (sum_adv >= {1'b0, rate_eff}) ? RW'(sum_adv - {1'b0, rate_eff})
                                                : sum_adv[RW-1:0];
  assign pos_inc = pos_r + STP_LOOP_W'(1);

  // numerator of the rounded phase index: r*8D + R, over 2R
  assign num_w = NW'(rem_res_r) * NW'(EIGHT_D) + NW'(rate_eff);

  assign sh_div = {rem_div_r, qlo_r[QW-1]};
  assign div2   = {1'b0, rate_eff, 1'b0};
  assign div_ge = (sh_div >= div2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r <= '0;
      pos_r     <= '0;
    end else if (cmd.start && in_restart) begin
      residue_r <= '0;
      pos_r     <= '0;
    end else if (cmd.mult) begin
      if (pos_inc >= loop_r) begin
        residue_r <= '0;
        pos_r     <= '0;
      end else begin
        residue_r <= res_adv;
        pos_r     <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_res_r <= in_restart ? '0 : residue_r;
      dvd_frq_r <= {1'b0, freq_r};
      rem_res_r <= '0;
      rem_frq_r <= '0;
    end else if (cmd.mod_step) begin
      dvd_res_r <= {dvd_res_r[RW-2:0], 1'b0};
      dvd_frq_r <= {dvd_frq_r[RW-2:0], 1'b0};
      rem_res_r <= rem_res_nxt;
      rem_frq_r <= rem_frq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      rem_div_r <= (RW + 1)'(num_w >> QW);
      qlo_r     <= num_w[QW-1:0];
    end else if (cmd.div_step) begin
      rem_div_r <= div_ge ? (RW + 1)'(sh_div - div2) : sh_div[RW:0];
      qlo_r     <= {qlo_r[QW-2:0], div_ge};
    end
  end

  // index 4D wraps to 0; then quadrant and mirrored table address
  always_comb begin
    idx_i = (qlo_r == QW'(4 * D)) ? '0 : qlo_r;
    if (idx_i < QW'(D)) begin
      quad_i = 2'd0;
      m_i    = idx_i;
    end else if (idx_i < QW'(2 * D)) begin
      quad_i = 2'd1;
      m_i    = idx_i - QW'(D);
    end else if (idx_i < QW'(3 * D)) begin
      quad_i = 2'd2;
      m_i    = idx_i - QW'(2 * D);
    end else begin
      quad_i = 2'd3;
      m_i    = idx_i - QW'(3 * D);
    end
    addr_nxt = quad_i[0] ? AW'(D) - AW'(m_i) : AW'(m_i);
  end

  always_ff @(posedge clk) begin
    if (cmd.quad) begin
      addr_r <= addr_nxt;
      neg_r  <= quad_i[1];
    end
  end

  for (genvar k = 0; k <= int'(D); k++) begin : g_rom
    localparam longint unsigned XQ30 = (longint'(k) << 30) / D;
    assign rom_w[k] = stp_quarter_sine(XQ30);
  end

  always_ff @(posedge clk) begin
    if (cmd.rom) begin
      rom_q_r <= rom_w[addr_r];
    end
  end

  // offset binary base and signed 16-bit value
  assign u_w   = neg_r ? 16'(STP_FULL_Q15) - {1'b0, rom_q_r}
                       : 16'(STP_FULL_Q15) + {1'b0, rom_q_r};
  assign s16_w = neg_r ? 16'(-{1'b0, rom_q_r}) : {1'b0, rom_q_r};

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      if (sgn_r) begin
        wide_res_r <= s16_w;
        prod_r     <= 24'({9'd0, rom_q_r} * 24'(STP_S8_SCALE));
      end else begin
        // u*65535/65534 is u, plus one at full scale
        wide_res_r <= (u_w == 16'(STP_U16_MAX - 1)) ? 16'(STP_U16_MAX) : u_w;
        prod_r     <= 24'(({8'd0, u_w} * 24'(STP_U8_SCALE)) >> 1);
      end
    end
  end

  // floor(a / 32767) as (a + (a >> 15) + 1) >> 15, exact below 2^30
  assign corr_w   = {1'b0, prod_r} + 25'(prod_r >> 15) + 25'd1;
  assign q8_w     = corr_w[22:15];
  assign narrow_w = (sgn_r && neg_r) ? 8'(-q8_w) : q8_w;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      sample_r <= wide_r ? wide_res_r : {8'd0, narrow_w};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.beat) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beat) begin
      out_sample_r  <= sample_r;
      out_channel_r <= cmd.beat_chan;
      out_last_r    <= cmd.beat_last;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.chan_cfg = ccnt_r;

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_channel      = out_channel_r;
  assign out_last_channel = out_last_r;

endmodule

[rtl/sine_tone_sample_generator_unit.sv]
// Sequence: an accepted tick runs residue reduction, phase division (13 steps at the
//   default table depth), quadrant fold, table read and scaling, then one beat per channel.
// A new tick is taken only after the last beat of a frame; the 18-step residue reduction
//   and the bit-serial phase division share one sequencer.
// Reset: synchronous, active low; registers return to their defaults, phase and frame
//   position to zero, the output register empties.
module sine_tone_sample_generator_unit #(
  parameter int MAX_CHANNELS     = stp_pkg::STP_MAX_CHANNELS,
  parameter int SINE_TABLE_DEPTH = stp_pkg::STP_SINE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_restart,
  // sample channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stp_pkg::STP_SAMPLE_W-1:0]   out_sample,
  output logic [stp_pkg::STP_CHAN_W-1:0]     out_channel,
  output logic                               out_last_channel,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stp_pkg::STP_CFG_IDX_W-1:0]  cfg_index,
  input  logic [stp_pkg::STP_CFG_DAT_W-1:0]  cfg_data
);
  import stp_pkg::*;

  stp_cmd_t cmd;
  stp_sts_t sts;
  logic     idle;

  // Ticks are taken only between frames. The last sample beat may still sit in the
  // output register when the next tick is accepted.
  assign in_stall = !idle;

  // Register writes always complete; the user must issue them only between frames, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Controller: sequences one frame.
  //   reduce residue and frequency mod rate (18 steps, both at once)
  //   -> r*8D + R and frame advance -> phase index division by 2R, one bit a step
  //   -> quadrant fold -> table read -> scaling -> one beat per channel
  stp_ctrl #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .idle     (idle),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: registers, phase state, shared restoring step units, quarter-wave table,
  // sample formatting and the output register.
  stp_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_channel      (out_channel),
    .out_last_channel (out_last_channel),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule
